[sv/psp_pkg.sv]
package psp_pkg;

  // Packet layout and symbol codes
  localparam int unsigned PACKET_BITS = 26;
  localparam int unsigned CNT_W       = $clog2(PACKET_BITS);
  localparam int unsigned ADDR_W      = 6;
  localparam int unsigned MAX_PIXELS  = 63;
  localparam int unsigned CFG_IDX_W   = 4;
  localparam int unsigned CFG_DATA_W  = 8;

  localparam logic [7:0] SYM_ZERO = 8'h7E;
  localparam logic [7:0] SYM_ONE  = 8'h40;

  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(PACKET_BITS - 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STRING_LENGTH = CFG_IDX_W'(1);

  typedef logic [PACKET_BITS-1:0] packet_t;

  // Keep the low six bits of the value and replace a zero result by the limit
  function automatic logic [ADDR_W-1:0] legal_length(input logic [CFG_DATA_W-1:0] v);
    logic [ADDR_W-1:0] n;
    n = v[ADDR_W-1:0];
    if (n == '0 || 32'(n) > MAX_PIXELS) begin
      return ADDR_W'(MAX_PIXELS);
    end
    return n;
  endfunction

endpackage

[sv/psp_serializer.sv]
module psp_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  psp_pkg::packet_t  packet,
  output logic              can_load,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_uart_symbol,
  output logic              out_last_symbol
);

  logic                     valid_r, valid_nxt;
  psp_pkg::packet_t         sh_r, sh_nxt;
  logic [psp_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                     fire;
  logic                     last;

  assign fire = valid_r && out_ready;
  assign last = (cnt_r == psp_pkg::LAST_BIT);

  // Take a new packet once the last word of the current one leaves
  assign can_load = !valid_r || (out_ready && last);

  // Load, shift out MSB first, drop when done
  always_comb begin
    valid_nxt = valid_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      valid_nxt = 1'b1;
      sh_nxt    = packet;
      cnt_nxt   = '0;
    end else if (fire) begin
      if (last) begin
        valid_nxt = 1'b0;
      end else begin
        sh_nxt  = {sh_r[psp_pkg::PACKET_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign out_valid       = valid_r;
  assign out_uart_symbol = sh_r[psp_pkg::PACKET_BITS-1] ? psp_pkg::SYM_ONE : psp_pkg::SYM_ZERO;
  assign out_last_symbol = last;

endmodule

[sv/pixel_string_packet_encoder.sv]
// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_ready    in_red, in_green, in_blue (8 bits each)
// out      output     out_valid/out_ready  out_uart_symbol (8), out_last_symbol (1)
// cfg      input      cfg_valid/cfg_ready  cfg_index (4), cfg_data (8)
//
// Each pixel yields 26 words, one per cycle while out_ready is high; the 26-bit
// shift register in the serializer sets that word count.
// A new pixel is taken in the cycle its predecessor's last word leaves.
// Reset clears the address counter and restores brightness 255, length 63.
// A stall on out holds the current word and blocks in; cfg_ready is always high.
module pixel_string_packet_encoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_red,
  input  logic [7:0]                       in_green,
  input  logic [7:0]                       in_blue,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_uart_symbol,
  output logic                             out_last_symbol,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [psp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [psp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic [7:0]                  bright_r, bright_nxt;
  logic [psp_pkg::ADDR_W-1:0]  len_r, len_nxt;
  logic [psp_pkg::ADDR_W-1:0]  addr_r, addr_nxt;
  logic [psp_pkg::ADDR_W-1:0]  addr_inc;
  logic                        can_load;
  logic                        in_fire;
  logic                        cfg_fire;
  psp_pkg::packet_t            packet;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = can_load;
  assign in_fire   = in_valid && in_ready;

  // Assemble address, brightness and the high nibbles of blue, green, red
  assign packet = {addr_r, bright_r, in_blue[7:4], in_green[7:4], in_red[7:4]};

  assign addr_inc = addr_r + 1'b1;

  // Register writes and address advance
  always_comb begin
    bright_nxt = bright_r;
    len_nxt    = len_r;
    addr_nxt   = addr_r;
    if (in_fire) begin
      addr_nxt = (addr_inc >= len_r) ? '0 : addr_inc;
    end
    if (cfg_fire) begin
      case (cfg_index)
        psp_pkg::REG_BRIGHTNESS: begin
          bright_nxt = cfg_data;
        end
        psp_pkg::REG_STRING_LENGTH: begin
          len_nxt  = psp_pkg::legal_length(cfg_data);
          addr_nxt = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bright_r <= 8'hFF;
      len_r    <= psp_pkg::legal_length(8'd63);
      addr_r   <= '0;
    end else begin
      bright_r <= bright_nxt;
      len_r    <= len_nxt;
      addr_r   <= addr_nxt;
    end
  end

  psp_serializer u_ser (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (in_fire),
    .packet          (packet),
    .can_load        (can_load),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_uart_symbol (out_uart_symbol),
    .out_last_symbol (out_last_symbol)
  );

endmodule

[sv/psp_checker.sv]
module psp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_uart_symbol,
  input logic       out_last_symbol
);

  // No new pixel while a packet is mid-flight
  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_symbol |-> !in_ready)
    else $error("input taken while packet still streaming");

  // A packet keeps streaming until its last word
  a_continue: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_symbol |=> out_valid)
    else $error("packet stream broke before last word");

  // An accepted pixel starts a fresh packet
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid && !out_last_symbol)
    else $error("accepted pixel did not start a packet");

  // Only the two symbol codes appear
  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_uart_symbol == psp_pkg::SYM_ONE || out_uart_symbol == psp_pkg::SYM_ZERO))
    else $error("unknown symbol code");

  // Hold a stalled word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_uart_symbol)
      && $stable(out_last_symbol))
    else $error("stalled word changed");

endmodule

bind pixel_string_packet_encoder psp_checker u_psp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_uart_symbol (out_uart_symbol),
  .out_last_symbol (out_last_symbol)
);
